/* rtl/core/psd_pkg.sv */
// ----------------------------------------------------------------------------
// psd_pkg: PackBits strip decoder package
// Shared types and constants for the strip decoder front, queue and top.
// ----------------------------------------------------------------------------
`default_nettype none

package psd_pkg;

  localparam int STRIP_W       = 24;
  localparam int BYTE_W        = 8;
  localparam int COUNT_W_DFLT  = 24;
  localparam logic [STRIP_W-1:0] STRIP_RESET = 24'd8192;
  localparam logic [BYTE_W-1:0]  NOOP_HEADER = 8'h80;  // -128

  typedef enum logic [1:0] {
    MODE_HEADER  = 2'd0,
    MODE_LITERAL = 2'd1,
    MODE_RUN     = 2'd2
  } psd_mode_t;

  typedef struct packed {
    logic [BYTE_W-1:0] value;
    logic [BYTE_W-1:0] repeat_count;
    logic              strip_end;
    logic              overrun;
  } psd_result_t;

endpackage

`default_nettype wire

/* rtl/core/psd_front.sv */
// ----------------------------------------------------------------------------
// psd_front: header parse and strip count
// Classifies each code byte as header, literal or run byte, keeps the
// decoded byte count and produces one result per data byte.
// ----------------------------------------------------------------------------
`default_nettype none

module psd_front #(
  parameter int COUNT_WIDTH = psd_pkg::COUNT_W_DFLT
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_we,
  input  wire logic [psd_pkg::STRIP_W-1:0] cfg_data,
  input  wire logic                      take,
  input  wire logic [psd_pkg::BYTE_W-1:0] code_byte,
  output logic                           res_valid,
  output psd_pkg::psd_result_t           res
);
  import psd_pkg::*;

  localparam int CMP_W = (COUNT_WIDTH + 1 > STRIP_W) ? COUNT_WIDTH + 1 : STRIP_W;

  psd_mode_t              mode_r, mode_nxt;
  logic [BYTE_W-1:0]      left_r, left_nxt;
  logic [BYTE_W-1:0]      run_r, run_nxt;
  logic [COUNT_WIDTH-1:0] count_r, count_nxt;
  logic [STRIP_W-1:0]     strip_r;

  logic [BYTE_W-1:0]      rep;
  logic [CMP_W-1:0]       sum;
  logic                   hit;

  always_comb begin
    mode_nxt  = mode_r;
    left_nxt  = left_r;
    run_nxt   = run_r;
    count_nxt = count_r;
    res_valid = 1'b0;
    rep       = 8'd1;
    case (mode_r)
      MODE_LITERAL: begin
        res_valid = take;
        rep       = 8'd1;
      end
      MODE_RUN: begin
        res_valid = take;
        rep       = run_r;
      end
      default: res_valid = 1'b0;
    endcase
    sum = CMP_W'(count_r) + CMP_W'(rep);
    hit = (sum >= CMP_W'(strip_r));
    res.value        = code_byte;
    res.repeat_count = rep;
    res.strip_end    = hit;
    res.overrun      = (sum > CMP_W'(strip_r));
    if (take) begin
      case (mode_r)
        MODE_LITERAL: begin
          left_nxt = left_r - 8'd1;
          if (left_nxt == '0) mode_nxt = MODE_HEADER;
        end
        MODE_RUN: mode_nxt = MODE_HEADER;
        default: begin
          if (!code_byte[BYTE_W-1]) begin
            left_nxt = code_byte + 8'd1;
            mode_nxt = MODE_LITERAL;
          end else if (code_byte != NOOP_HEADER) begin
            run_nxt  = ~code_byte + 8'd2;
            mode_nxt = MODE_RUN;
          end else begin
            mode_nxt = MODE_HEADER;
          end
        end
      endcase
      if (res_valid) begin
        if (hit) begin
          count_nxt = '0;
          mode_nxt  = MODE_HEADER;
          left_nxt  = '0;
        end else begin
          count_nxt = sum[COUNT_WIDTH-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_HEADER;
      left_r  <= '0;
      run_r   <= '0;
      count_r <= '0;
      strip_r <= STRIP_RESET;
    end else begin
      mode_r  <= mode_nxt;
      left_r  <= left_nxt;
      run_r   <= run_nxt;
      count_r <= count_nxt;
      if (cfg_we) strip_r <= cfg_data;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/psd_queue.sv */
// ----------------------------------------------------------------------------
// psd_queue: result queue and output stage
// Two-entry queue between the front and the result channel; the head entry
// drives the output ports directly.
// ----------------------------------------------------------------------------
`default_nettype none

module psd_queue (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 wr_en,
  input  wire psd_pkg::psd_result_t wr_data,
  output logic                      full,
  output logic                      rd_valid,
  input  wire logic                 rd_stall,
  output psd_pkg::psd_result_t      rd_data
);
  import psd_pkg::*;

  psd_result_t mem_r [2];
  logic        wp_r, wp_nxt;
  logic        rp_r, rp_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        rd_en;

  assign full     = (cnt_r == 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_en    = rd_valid && !rd_stall;
  assign rd_data  = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r ^ wr_en;
    rp_nxt  = rp_r ^ rd_en;
    cnt_nxt = cnt_r + {1'b0, wr_en} - {1'b0, rd_en};
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/packbits_strip_decoder.sv */
// ----------------------------------------------------------------------------
// packbits_strip_decoder: PackBits strip decoder
// Decodes PackBits code bytes into value / repeat count results and marks
// the result that completes a strip.
//
//   channel | dir | transfer when      | payload
//   in_     | in  | in_valid & !in_stall   | in_code_byte
//   out_    | out | out_valid & !out_stall | out_value, out_repeat_count,
//           |     |                        | out_strip_end, out_overrun
//   cfg_    | in  | cfg_we                 | cfg_data (strip_bytes)
//
// One code byte per cycle while in_stall is low; results leave from the queue head.
// The two-entry result queue sets in_stall while it is full.
// Reset is synchronous; strip_bytes returns to 8192.
// ----------------------------------------------------------------------------
`default_nettype none

module packbits_strip_decoder #(
  parameter int COUNT_WIDTH = psd_pkg::COUNT_W_DFLT
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic [psd_pkg::STRIP_W-1:0] cfg_data,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [psd_pkg::BYTE_W-1:0]  in_code_byte,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [psd_pkg::BYTE_W-1:0]       out_value,
  output logic [psd_pkg::BYTE_W-1:0]       out_repeat_count,
  output logic                             out_strip_end,
  output logic                             out_overrun
);
  import psd_pkg::*;

  logic        take;
  logic        res_valid;
  logic        q_full;
  psd_result_t res;
  psd_result_t head;

  assign in_stall = q_full;
  assign take     = in_valid && !q_full;

  psd_front #(.COUNT_WIDTH(COUNT_WIDTH)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .take      (take),
    .code_byte (in_code_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  psd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (res_valid),
    .wr_data  (res),
    .full     (q_full),
    .rd_valid (out_valid),
    .rd_stall (out_stall),
    .rd_data  (head)
  );

  assign out_value        = head.value;
  assign out_repeat_count = head.repeat_count;
  assign out_strip_end    = head.strip_end;
  assign out_overrun      = head.overrun;

endmodule

`default_nettype wire

/* tb/sv/packbits_strip_decoder_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packbits_strip_decoder_tb: self-checking testbench for the strip decoder
// Feeds PackBits code bytes with random gaps and result stalls. A byte-level
// model of the decoder predicts each value/repeat result, and a monitor
// compares every result transfer in order. Directed cases cover literal
// and run headers, the no-op header, strip end inside a literal, overrun
// and the smallest strip size. Random phases follow at several strip sizes.
// ----------------------------------------------------------------------------
module packbits_strip_decoder_tb;
  import psd_pkg::*;

  localparam int CNT_W       = COUNT_W_DFLT;
  localparam int STALL_MAX   = 13;
  localparam int WDOG_LIMIT  = 2000;
  localparam int DRAIN_WAIT  = 10;

  logic                clk              = 1'b0;
  logic                rst_n            = 1'b0;
  logic                cfg_we           = 1'b0;
  logic [STRIP_W-1:0]  cfg_data         = '0;
  logic                in_valid         = 1'b0;
  logic                in_stall;
  logic [BYTE_W-1:0]   in_code_byte     = '0;
  logic                out_valid;
  logic                out_stall        = 1'b0;
  logic [BYTE_W-1:0]   out_value;
  logic [BYTE_W-1:0]   out_repeat_count;
  logic                out_strip_end;
  logic                out_overrun;

  packbits_strip_decoder dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_code_byte     (in_code_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_value        (out_value),
    .out_repeat_count (out_repeat_count),
    .out_strip_end    (out_strip_end),
    .out_overrun      (out_overrun)
  );

  always #1 clk = ~clk;

  // decoder model state
  logic [STRIP_W-1:0] strip_bytes   = STRIP_RESET;
  psd_mode_t          mode          = MODE_HEADER;
  logic [BYTE_W-1:0]  literal_left  = '0;
  logic [BYTE_W-1:0]  run_length    = '0;
  logic [CNT_W-1:0]   decoded_count = '0;

  psd_result_t pending_results[$];
  int          error_count = 0;
  int          bytes_sent  = 0;
  bit          in_gaps_on  = 1'b1;
  bit          out_stall_on = 1'b1;
  int          stall_left  = 0;
  int          quiet_cycles = 0;

  task automatic emit_result(input logic [BYTE_W-1:0] value, input logic [BYTE_W-1:0] count);
    logic [CNT_W:0] sum;
    psd_result_t    res;
    sum = {1'b0, decoded_count} + CNT_W'(count);
    res.value        = value;
    res.repeat_count = count;
    res.strip_end    = (sum >= (CNT_W+1)'(strip_bytes));
    res.overrun      = (sum >  (CNT_W+1)'(strip_bytes));
    if (res.strip_end) begin
      decoded_count = '0;
      mode          = MODE_HEADER;
      literal_left  = '0;
    end else begin
      decoded_count = sum[CNT_W-1:0];
    end
    pending_results = {pending_results, res};
  endtask

  task automatic decode_code_byte(input logic [BYTE_W-1:0] b);
    case (mode)
      MODE_LITERAL: begin
        literal_left = literal_left - 1'b1;
        if (literal_left == '0) mode = MODE_HEADER;
        emit_result(b, 8'd1);
      end
      MODE_RUN: begin
        mode = MODE_HEADER;
        emit_result(b, run_length);
      end
      default: begin
        if (!b[BYTE_W-1]) begin
          literal_left = b + 1'b1;
          mode         = MODE_LITERAL;
        end else if (b != NOOP_HEADER) begin
          run_length = 8'(9'd257 - {1'b0, b});
          mode       = MODE_RUN;
        end else begin
          mode = MODE_HEADER;
        end
      end
    endcase
  endtask

  task automatic push_code_byte(input logic [BYTE_W-1:0] b);
    int gap;
    gap = in_gaps_on ? $urandom_range(0, STALL_MAX) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_code_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    decode_code_byte(b);
    bytes_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_strip_bytes(input logic [STRIP_W-1:0] v);
    wait_idle();
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    strip_bytes = v;
  endtask

  // one header with its data, or some noise
  task automatic send_packet();
    int kind;
    int len;
    int i;
    kind = $urandom_range(0, 99);
    if (kind < 45) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 7);
      push_code_byte(8'(len));
      for (i = 0; i <= len; i++) push_code_byte(8'($urandom_range(0, 255)));
    end else if (kind < 85) begin
      push_code_byte(8'($urandom_range(129, 255)));
      push_code_byte(8'($urandom_range(0, 255)));
    end else if (kind < 90) begin
      push_code_byte(NOOP_HEADER);
    end else begin
      len = $urandom_range(1, 4);
      for (i = 0; i < len; i++) push_code_byte(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic test_literal_and_run();
    push_code_byte(8'h00); push_code_byte(8'hFF);
    push_code_byte(8'h01); push_code_byte(8'h00); push_code_byte(8'hAA);
    push_code_byte(8'hFF); push_code_byte(8'h55);
    push_code_byte(8'h81); push_code_byte(8'h80);
    push_code_byte(NOOP_HEADER);
  endtask

  task automatic test_strip_end();
    set_strip_bytes(24'd3);
    // strip ends inside a literal; the rest of it is dropped
    push_code_byte(8'h7F); push_code_byte(8'h11);
    push_code_byte(8'h22); push_code_byte(8'h33);
    // next byte is a header again; run of 4 overshoots
    push_code_byte(8'hFD); push_code_byte(8'h44);
  endtask

  task automatic test_min_strip();
    set_strip_bytes(24'd1);
    push_code_byte(8'h00); push_code_byte(8'h00);
    push_code_byte(8'h81); push_code_byte(8'hFF);
  endtask

  task automatic test_random(input int count, input logic [STRIP_W-1:0] size,
                             input bit gaps, input bit stalls);
    int target;
    set_strip_bytes(size);
    in_gaps_on   = gaps;
    out_stall_on = stalls;
    target = bytes_sent + count;
    while (bytes_sent < target) send_packet();
  endtask

  // result monitor and stall generator
  always @(posedge clk) begin
    psd_result_t exp_res;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: value %0d count %0d", out_value, out_repeat_count);
        error_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (out_value !== exp_res.value) begin
          $error("out_value: expected %0d, got %0d", exp_res.value, out_value);
          error_count++;
        end
        if (out_repeat_count !== exp_res.repeat_count) begin
          $error("out_repeat_count: expected %0d, got %0d",
                 exp_res.repeat_count, out_repeat_count);
          error_count++;
        end
        if (out_strip_end !== exp_res.strip_end) begin
          $error("out_strip_end: expected %0d, got %0d", exp_res.strip_end, out_strip_end);
          error_count++;
        end
        if (out_overrun !== exp_res.overrun) begin
          $error("out_overrun: expected %0d, got %0d", exp_res.overrun, out_overrun);
          error_count++;
        end
      end
      stall_left = out_stall_on ? $urandom_range(0, STALL_MAX) : 0;
      out_stall <= (stall_left != 0);
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= (stall_left != 0);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_literal_and_run();
    test_strip_end();
    test_min_strip();
    test_random(300, 24'($urandom_range(1, 64)), 1'b1, 1'b1);
    test_random(200, 24'hFFFFFF, 1'b1, 1'b0);
    test_random(150, 24'd1, 1'b0, 1'b1);
    test_random(300, 24'($urandom_range(65, 2000)), 1'b1, 1'b1);
    test_random(250, STRIP_RESET, 1'b1, 1'b1);
    test_random(150, 24'($urandom_range(1, 40)), 1'b0, 1'b0);
    wait_idle();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
